>>> src/stir_pkg.sv
`timescale 1ns / 1ps

package stir_pkg;

    // Reset position of the cursor, in pixels.
    localparam int unsigned CENTER_X_DEF = 512;
    localparam int unsigned CENTER_Y_DEF = 384;

    // Queue depths between the parts (powers of two, at least two).
    localparam int unsigned OP_DEPTH_DEF  = 2;
    localparam int unsigned OUT_DEPTH_DEF = 4;

    // Largest cursor position in eighth pixels.
    localparam logic [13:0] POS_MAX = 14'd8184;

    // Blob coordinate shown while the cursor is idle.
    localparam logic [9:0] POS_IDLE = 10'h3FF;

    // Request commands.
    localparam logic [1:0] CMD_MOVE   = 2'd0;
    localparam logic [1:0] CMD_REPORT = 2'd1;
    localparam logic [1:0] CMD_OFF    = 2'd2;
    localparam logic [1:0] CMD_INIT   = 2'd3;

    // Report layouts.
    localparam logic [1:0] MODE_BASIC = 2'd0;
    localparam logic [1:0] MODE_EXT   = 2'd1;
    localparam logic [1:0] MODE_FULL  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_REPORT_MODE  = 3'd0;
    localparam logic [2:0] REG_SENSITIVITY  = 3'd1;
    localparam logic [2:0] REG_DEAD_RADIUS  = 3'd2;
    localparam logic [2:0] REG_STICK_ENABLE = 3'd3;
    localparam logic [2:0] REG_BLOB_OFFSET  = 3'd4;
    localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd5;
    localparam logic [2:0] REG_BLOB_SIZE    = 3'd6;

    // Register reset values.
    localparam logic [1:0]  RST_REPORT_MODE  = MODE_BASIC;
    localparam logic [7:0]  RST_SENSITIVITY  = 8'd128;
    localparam logic [7:0]  RST_DEAD_RADIUS  = 8'd0;
    localparam logic        RST_STICK_ENABLE = 1'b1;
    localparam logic [8:0]  RST_BLOB_OFFSET  = 9'd64;
    localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd1000;
    localparam logic [3:0]  RST_BLOB_SIZE    = 4'd1;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] stick_x_raw;
        logic [7:0] stick_y_raw;
        logic [7:0] stick_x_cal;
        logic [7:0] stick_y_cal;
    } in_item_t;

    typedef struct packed {
        logic [7:0] report_byte;
        logic       last_byte;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  report_mode;
        logic [7:0]  sensitivity;
        logic [7:0]  dead_radius;
        logic        stick_enable;
        logic [8:0]  blob_offset;
        logic [15:0] idle_timeout;
        logic [3:0]  blob_size;
    } cfg_t;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        logic [1:0]        command;
        logic              deflect;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
    } op_t;

    // Index of the final byte of a report in each layout.
    function automatic logic [5:0] last_index_f(input logic [1:0] mode);
        logic [5:0] n;
        begin
            case (mode)
                MODE_BASIC: n = 6'd9;
                MODE_EXT:   n = 6'd11;
                MODE_FULL:  n = 6'd35;
                default:    n = 6'd0;
            endcase
            return n;
        end
    endfunction

    // One report byte by layout and position.
    function automatic logic [7:0] report_byte_f(
        input logic [1:0] mode,
        input logic [5:0] idx,
        input logic [9:0] p0,
        input logic [9:0] p1,
        input logic [9:0] p2,
        input logic [9:0] p3,
        input logic [3:0] size
    );
        logic [7:0] b;
        logic [5:0] k;
        logic [9:0] px;
        logic [9:0] py;
        begin
            b  = 8'hFF;
            k  = 6'd0;
            px = p0;
            py = p1;
            case (mode)
                MODE_BASIC:
                begin
                    case (idx)
                        6'd0:    b = p0[7:0];
                        6'd1:    b = p1[7:0];
                        6'd2:    b = {p1[9:8], p0[9:8], p3[9:8], p2[9:8]};
                        6'd3:    b = p2[7:0];
                        6'd4:    b = p3[7:0];
                        default: b = 8'hFF;
                    endcase
                end
                MODE_EXT:
                begin
                    case (idx)
                        6'd0:       b = p0[7:0];
                        6'd1:       b = p1[7:0];
                        6'd2:       b = {p1[9:8], p0[9:8], size};
                        6'd3:       b = p2[7:0];
                        6'd4:       b = p3[7:0];
                        6'd5:       b = {p3[9:8], p2[9:8], size};
                        6'd8, 6'd11: b = 8'hF0;
                        default:    b = 8'hFF;
                    endcase
                end
                MODE_FULL:
                begin
                    if (idx < 6'd18)
                    begin
                        // Two visible blobs, nine bytes each.
                        k  = (idx >= 6'd9) ? idx - 6'd9 : idx;
                        px = (idx >= 6'd9) ? p2 : p0;
                        py = (idx >= 6'd9) ? p3 : p1;
                        case (k)
                            6'd0:             b = px[7:0];
                            6'd1:             b = py[7:0];
                            6'd2:             b = {py[9:8], px[9:8], size};
                            6'd3, 6'd5, 6'd7: b = 8'h00;
                            6'd4, 6'd6:       b = 8'h7F;
                            default:          b = 8'hFF;
                        endcase
                    end
                    else
                    begin
                        // Two empty blob slots.
                        k = (idx >= 6'd27) ? idx - 6'd27 : idx - 6'd18;
                        case (k)
                            6'd0, 6'd1, 6'd8: b = 8'hFF;
                            6'd2:             b = 8'hF0;
                            default:          b = 8'h00;
                        endcase
                    end
                end
                default: b = 8'hFF;
            endcase
            return b;
        end
    endfunction

endpackage

>>> src/stir_fifo.sv
`timescale 1ns / 1ps

module stir_fifo #(
    parameter type         T     = logic,
    parameter int unsigned DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  T     wr_data,
    output logic full,
    input  logic rd_en,
    output T     rd_data,
    output logic empty
);

    localparam int unsigned AW = $clog2(DEPTH);

    T mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [AW:0]   count_reg;
    logic [AW:0]   count_next;
    logic          do_wr;
    logic          do_rd;

    // Status and oldest entry.
    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Pointer and count updates.
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> src/stir_regs.sv
`timescale 1ns / 1ps

module stir_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          mode_clr,
    output stir_pkg::cfg_t cfg
);

    import stir_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign index  = paddr[4:2];
    assign cfg    = cfg_reg;

    // Register writes; reinitialize turns the no-report layout back to basic.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (mode_clr && (cfg_reg.report_mode == MODE_NONE))
        begin
            cfg_next.report_mode = MODE_BASIC;
        end
        if (wr_en)
        begin
            case (index)
                REG_REPORT_MODE:  cfg_next.report_mode  = pwdata[1:0];
                REG_SENSITIVITY:  cfg_next.sensitivity  = pwdata[7:0];
                REG_DEAD_RADIUS:  cfg_next.dead_radius  = pwdata[7:0];
                REG_STICK_ENABLE: cfg_next.stick_enable = pwdata[0];
                REG_BLOB_OFFSET:  cfg_next.blob_offset  = pwdata[8:0];
                REG_IDLE_TIMEOUT: cfg_next.idle_timeout = pwdata[15:0];
                REG_BLOB_SIZE:    cfg_next.blob_size    = pwdata[3:0];
                default:          cfg_next = cfg_next;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.report_mode  <= RST_REPORT_MODE;
            cfg_reg.sensitivity  <= RST_SENSITIVITY;
            cfg_reg.dead_radius  <= RST_DEAD_RADIUS;
            cfg_reg.stick_enable <= RST_STICK_ENABLE;
            cfg_reg.blob_offset  <= RST_BLOB_OFFSET;
            cfg_reg.idle_timeout <= RST_IDLE_TIMEOUT;
            cfg_reg.blob_size    <= RST_BLOB_SIZE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back.
    always_comb
    begin
        case (index)
            REG_REPORT_MODE:  prdata = {30'd0, cfg_reg.report_mode};
            REG_SENSITIVITY:  prdata = {24'd0, cfg_reg.sensitivity};
            REG_DEAD_RADIUS:  prdata = {24'd0, cfg_reg.dead_radius};
            REG_STICK_ENABLE: prdata = {31'd0, cfg_reg.stick_enable};
            REG_BLOB_OFFSET:  prdata = {23'd0, cfg_reg.blob_offset};
            REG_IDLE_TIMEOUT: prdata = {16'd0, cfg_reg.idle_timeout};
            REG_BLOB_SIZE:    prdata = {28'd0, cfg_reg.blob_size};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

>>> src/stir_front.sv
`timescale 1ns / 1ps

module stir_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  stir_pkg::in_item_t request,
    output logic               full,
    input  stir_pkg::cfg_t     cfg,
    output logic               op_valid,
    output stir_pkg::op_t      op,
    input  logic               op_full
);

    import stir_pkg::*;

    logic               op_valid_reg;
    logic               op_valid_next;
    op_t                op_reg;
    op_t                op_next;
    logic               accept;
    logic signed [8:0]  rx;
    logic signed [8:0]  ry;
    logic signed [17:0] sqx;
    logic signed [17:0] sqy;
    logic [16:0]        dist_sq;
    logic [15:0]        r2;
    logic               dead;
    logic signed [8:0]  jx;
    logic signed [8:0]  jy;
    logic signed [7:0]  sx;
    logic signed [7:0]  sy;
    logic               deflect;

    // Deflection times sensitivity over 256, truncated toward zero.
    function automatic logic signed [7:0] scale_f(
        input logic signed [8:0] d,
        input logic [7:0]        sens
    );
        logic signed [17:0] prod;
        logic signed [17:0] adj;
        begin
            prod = 18'(d) * 18'($signed({1'b0, sens}));
            adj  = prod[17] ? prod + 18'sd255 : prod;
            return 8'(adj >>> 8);
        end
    endfunction

    assign accept   = push && !full;
    assign full     = op_valid_reg && op_full;
    assign op_valid = op_valid_reg;
    assign op       = op_reg;

    // Circular deadzone on the raw sample.
    always_comb
    begin
        rx      = $signed({1'b0, request.stick_x_raw}) - 9'sd128;
        ry      = $signed({1'b0, request.stick_y_raw}) - 9'sd128;
        sqx     = 18'(rx) * 18'(rx);
        sqy     = 18'(ry) * 18'(ry);
        dist_sq = {1'b0, sqx[15:0]} + {1'b0, sqy[15:0]};
        r2      = {8'd0, cfg.dead_radius} * {8'd0, cfg.dead_radius};
        dead    = dist_sq < {1'b0, r2};
    end

    // Scaled deflection of the calibrated sample.
    always_comb
    begin
        jx      = 9'sd128 - $signed({1'b0, request.stick_x_cal});
        jy      = 9'sd128 - $signed({1'b0, request.stick_y_cal});
        sx      = scale_f(jx, cfg.sensitivity);
        sy      = scale_f(jy, cfg.sensitivity);
        deflect = !dead && cfg.stick_enable && ((jx != 9'sd0) || (jy != 9'sd0));

        op_next.command = request.command;
        op_next.deflect = deflect;
        op_next.dx      = deflect ? sx : 8'sd0;
        op_next.dy      = deflect ? sy : 8'sd0;
    end

    // Output stage toward the operation queue.
    always_comb
    begin
        op_valid_next = op_valid_reg;
        if (accept)
        begin
            op_valid_next = 1'b1;
        end
        else if (op_valid_reg && !op_full)
        begin
            op_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg <= op_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_next;
        end
    end

endmodule

>>> src/stir_back.sv
`timescale 1ns / 1ps

module stir_back #(
    parameter int unsigned CENTER_X = stir_pkg::CENTER_X_DEF,
    parameter int unsigned CENTER_Y = stir_pkg::CENTER_Y_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  stir_pkg::cfg_t      cfg,
    input  logic                op_valid,
    input  stir_pkg::op_t       op,
    output logic                op_pop,
    output logic                mode_clr,
    output logic                out_push,
    output stir_pkg::out_item_t out_item,
    input  logic                out_full
);

    import stir_pkg::*;

    localparam logic [13:0] HOME_X = 14'(CENTER_X * 8);
    localparam logic [13:0] HOME_Y = 14'(CENTER_Y * 8);

    logic [13:0] cursor_x_reg;
    logic [13:0] cursor_x_next;
    logic [13:0] cursor_y_reg;
    logic [13:0] cursor_y_next;
    logic [16:0] ticks_reg;
    logic [16:0] ticks_next;
    logic        idle_reg;
    logic        idle_next;
    logic        busy_reg;
    logic        busy_next;
    logic [5:0]  idx_reg;
    logic [5:0]  idx_next;
    logic [1:0]  mode_reg;
    logic [9:0]  p0_reg;
    logic [9:0]  p1_reg;
    logic [9:0]  p2_reg;

    logic signed [14:0] sum_x;
    logic signed [14:0] sum_y;
    logic signed [14:0] lo_x;
    logic signed [14:0] hi_x;
    logic [13:0]        move_x;
    logic [13:0]        move_y;
    logic [16:0]        ticks_mid;
    logic               idle_mid;
    logic [9:0]         pos_x1;
    logic [9:0]         pos_x2;
    logic [9:0]         pos_y;
    logic               start;
    logic               last;

    assign op_pop   = op_valid && !busy_reg;
    assign mode_clr = op_pop && (op.command == CMD_INIT);
    assign start    = op_pop && (op.command == CMD_REPORT) && (cfg.report_mode != MODE_NONE);

    // Cursor step with clamping.
    always_comb
    begin
        sum_x = $signed({1'b0, cursor_x_reg}) + 15'(op.dx);
        sum_y = $signed({1'b0, cursor_y_reg}) + 15'(op.dy);
        lo_x  = $signed({6'd0, cfg.blob_offset});
        hi_x  = $signed({1'b0, POS_MAX}) - lo_x;
        if (sum_x < lo_x)
        begin
            move_x = 14'(lo_x);
        end
        else if (sum_x > hi_x)
        begin
            move_x = 14'(hi_x);
        end
        else
        begin
            move_x = 14'(sum_x);
        end
        if (sum_y < 15'sd0)
        begin
            move_y = 14'd0;
        end
        else if (sum_y > $signed({1'b0, POS_MAX}))
        begin
            move_y = POS_MAX;
        end
        else
        begin
            move_y = 14'(sum_y);
        end
    end

    // Cursor and idle state per command.
    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        ticks_next    = ticks_reg;
        idle_next     = idle_reg;
        ticks_mid     = op.deflect ? 17'd0 : ticks_reg;
        idle_mid      = op.deflect ? 1'b0 : idle_reg;
        if (op_pop)
        begin
            case (op.command)
                CMD_MOVE:
                begin
                    ticks_next = ticks_mid;
                    idle_next  = idle_mid;
                    if (!idle_mid)
                    begin
                        cursor_x_next = move_x;
                        cursor_y_next = move_y;
                        ticks_next    = ticks_mid + 17'd1;
                    end
                    if (ticks_next > {1'b0, cfg.idle_timeout})
                    begin
                        ticks_next = 17'd0;
                        idle_next  = 1'b1;
                    end
                end
                CMD_OFF:
                begin
                    idle_next = 1'b1;
                end
                CMD_INIT:
                begin
                    cursor_x_next = HOME_X;
                    cursor_y_next = HOME_Y;
                    ticks_next    = 17'd0;
                    idle_next     = 1'b1;
                end
                default:
                begin
                    idle_next = idle_reg;
                end
            endcase
        end
    end

    // Blob positions; the low ten bits wrap.
    always_comb
    begin
        pos_x1 = cursor_x_reg[12:3] + {1'b0, cfg.blob_offset};
        pos_x2 = cursor_x_reg[12:3] - {1'b0, cfg.blob_offset};
        pos_y  = cursor_y_reg[12:3];
        if (idle_reg)
        begin
            pos_x1 = POS_IDLE;
            pos_x2 = POS_IDLE;
            pos_y  = POS_IDLE;
        end
    end

    // Byte sequencer for a report burst.
    assign last              = (idx_reg == last_index_f(mode_reg));
    assign out_push          = busy_reg && !out_full;
    assign out_item.report_byte = report_byte_f(mode_reg, idx_reg, p0_reg, p1_reg,
                                                p2_reg, p1_reg, cfg.blob_size);
    assign out_item.last_byte = last;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = 6'd0;
        end
        else if (out_push)
        begin
            busy_next = !last;
            idx_next  = idx_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= HOME_X;
            cursor_y_reg <= HOME_Y;
            ticks_reg    <= 17'd0;
            idle_reg     <= 1'b1;
            busy_reg     <= 1'b0;
            idx_reg      <= 6'd0;
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            ticks_reg    <= ticks_next;
            idle_reg     <= idle_next;
            busy_reg     <= busy_next;
            idx_reg      <= idx_next;
        end
    end

    // Snapshot of the report contents.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= cfg.report_mode;
            p0_reg   <= pos_x1;
            p1_reg   <= pos_y;
            p2_reg   <= pos_x2;
        end
    end

endmodule

>>> src/stick_to_ir_blob_report.sv
`timescale 1ns / 1ps
// A report request passes the front output register and the operation queue; the
// back-end snapshot then feeds the result queue. Move, switch-off and reinitialize
// requests run one per cycle while no report is being sent and the queues have room;
// a report holds the sequencer, one byte per cycle while the result queue has room.
// Reset (rst_n, asynchronous, active low): cursor centered and idle, queues empty,
// registers at their defaults; no clearing pass, requests are taken right away.

module stick_to_ir_blob_report #(
    parameter int unsigned CENTER_X  = stir_pkg::CENTER_X_DEF,
    parameter int unsigned CENTER_Y  = stir_pkg::CENTER_Y_DEF,
    parameter int unsigned OP_DEPTH  = stir_pkg::OP_DEPTH_DEF,
    parameter int unsigned OUT_DEPTH = stir_pkg::OUT_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  stir_pkg::in_item_t  request,
    output logic                empty,
    input  logic                pop,
    output stir_pkg::out_item_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    import stir_pkg::*;

    cfg_t      cfg;
    logic      mode_clr;
    logic      front_valid;
    op_t       front_op;
    logic      op_full;
    logic      op_empty;
    op_t       back_op;
    logic      op_pop;
    logic      out_push;
    out_item_t out_item;
    logic      out_full;

    // Configuration registers.
    stir_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .mode_clr (mode_clr),
        .cfg      (cfg)
    );

    // Request classification.
    stir_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .request  (request),
        .full     (full),
        .cfg      (cfg),
        .op_valid (front_valid),
        .op       (front_op),
        .op_full  (op_full)
    );

    // Queue of classified requests.
    stir_fifo #(
        .T     (op_t),
        .DEPTH (OP_DEPTH)
    ) u_op_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_op),
        .full    (op_full),
        .rd_en   (op_pop),
        .rd_data (back_op),
        .empty   (op_empty)
    );

    // Cursor state and report sequencer.
    stir_back #(
        .CENTER_X (CENTER_X),
        .CENTER_Y (CENTER_Y)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .op_valid (!op_empty),
        .op       (back_op),
        .op_pop   (op_pop),
        .mode_clr (mode_clr),
        .out_push (out_push),
        .out_item (out_item),
        .out_full (out_full)
    );

    // Result queue.
    stir_fifo #(
        .T     (out_item_t),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_item),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule
